@@ sv/tla_pkg.sv @@
// ----------------------------------------------------------------------------
// tla_pkg
// shared types and constants of the toroidal life automaton
// ----------------------------------------------------------------------------
package tla_pkg;

  // grid storage limits
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // register widths
  localparam int SIZE_W  = 7;
  localparam int COUNT_W = 16;
  localparam int DATA_W  = 32;

  // smallest grid side in use
  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);

  // b3/s23 rule
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // register map
  localparam int NUM_REGS  = 3;
  localparam int ADDR_W    = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_GEN_COUNT   = REG_IDX_W'(2);

  // opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] row;
    logic [5:0] column;
    logic       new_cell;
  } in_t;

  typedef struct packed {
    logic read_cell;
    logic status;
  } out_t;

  // configuration as seen by the sequencer, sizes already clamped
  typedef struct packed {
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [COUNT_W-1:0] gen_count;
  } cfg_t;

endpackage

@@ sv/tla_bank.sv @@
// ----------------------------------------------------------------------------
// tla_bank
// single port row memory with per bit write enable and registered read
// ----------------------------------------------------------------------------
module tla_bank #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     re,
  input  logic [WIDTH-1:0]         we_mask,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIDTH; i++) begin
      if (we_mask[i]) begin
        mem[addr][i] <= wdata[i];
      end
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/tla_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tla_cfg_regs
// apb register file for grid size and generation count
// ----------------------------------------------------------------------------
module tla_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tla_pkg::ADDR_W-1:0]  paddr,
  input  logic [tla_pkg::DATA_W-1:0]  pwdata,
  output logic [tla_pkg::DATA_W-1:0]  prdata,
  output tla_pkg::cfg_t               cfg
);
  import tla_pkg::*;

  logic [SIZE_W-1:0]    grid_width_r;
  logic [SIZE_W-1:0]    grid_height_r;
  logic [COUNT_W-1:0]   gen_count_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= SIZE_W'(MAX_WIDTH);
      grid_height_r <= SIZE_W'(MAX_HEIGHT);
      gen_count_r   <= COUNT_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GRID_WIDTH:  grid_width_r  <= pwdata[SIZE_W-1:0];
        REG_GRID_HEIGHT: grid_height_r <= pwdata[SIZE_W-1:0];
        REG_GEN_COUNT:   gen_count_r   <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_WIDTH:  prdata = DATA_W'(grid_width_r);
      REG_GRID_HEIGHT: prdata = DATA_W'(grid_height_r);
      REG_GEN_COUNT:   prdata = DATA_W'(gen_count_r);
      default:         prdata = '0;
    endcase
  end

  // clamp sizes into the range the storage supports
  always_comb begin
    priority if (grid_width_r < MIN_SIZE)            cfg.width = MIN_SIZE;
    else if (grid_width_r > SIZE_W'(MAX_WIDTH))      cfg.width = SIZE_W'(MAX_WIDTH);
    else                                             cfg.width = grid_width_r;
    priority if (grid_height_r < MIN_SIZE)           cfg.height = MIN_SIZE;
    else if (grid_height_r > SIZE_W'(MAX_HEIGHT))    cfg.height = SIZE_W'(MAX_HEIGHT);
    else                                             cfg.height = grid_height_r;
    cfg.gen_count = gen_count_r;
  end

endmodule

@@ sv/tla_row_logic.sv @@
// ----------------------------------------------------------------------------
// tla_row_logic
// next state of one grid row from its north, own and south rows
// ----------------------------------------------------------------------------
module tla_row_logic (
  input  logic [tla_pkg::MAX_WIDTH-1:0] north,
  input  logic [tla_pkg::MAX_WIDTH-1:0] mid,
  input  logic [tla_pkg::MAX_WIDTH-1:0] south,
  input  logic [tla_pkg::SIZE_W-1:0]    width,
  output logic [tla_pkg::MAX_WIDTH-1:0] next_row,
  output logic [tla_pkg::MAX_WIDTH-1:0] use_mask,
  output logic                          changed
);
  import tla_pkg::*;

  always_comb begin
    logic [COL_W-1:0] last_col;
    logic [COL_W-1:0] west_idx;
    logic [COL_W-1:0] east_idx;
    logic [3:0]       cnt;
    last_col = COL_W'(width - SIZE_W'(1));
    changed  = 1'b0;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      // columns wrap at the configured width
      west_idx = (c == 0) ? last_col : COL_W'(c - 1);
      east_idx = ((COL_W'(c) == last_col) || (c == MAX_WIDTH - 1)) ? '0 : COL_W'(c + 1);
      cnt = 4'(north[west_idx]) + 4'(north[c]) + 4'(north[east_idx])
          + 4'(mid[west_idx])                  + 4'(mid[east_idx])
          + 4'(south[west_idx]) + 4'(south[c]) + 4'(south[east_idx]);
      next_row[c] = (cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && mid[c]);
      use_mask[c] = (SIZE_W'(c) < width);
      changed     = changed | (use_mask[c] & (next_row[c] ^ mid[c]));
    end
  end

endmodule

@@ sv/toroidal_life_automaton.sv @@
// ----------------------------------------------------------------------------
// toroidal_life_automaton
// b3/s23 life on a wrapping grid held in two ping-pong row memories
// ----------------------------------------------------------------------------
// write cell: response state, then the output register; read cell: bank read,
//   read state, response state, then the output register
// run: one row per cycle through the single read port of the source bank;
//   a generation that changes nothing ends the run early
// one item at a time; a new item is taken while the last result waits
// reset: sequencer idle, visible bank zero, registers 64 / 64 / 1;
//   cell memories are not cleared and must be written by the host
// ----------------------------------------------------------------------------
module toroidal_life_automaton (
  input  logic                       clk,
  input  logic                       rst_n,
  // item input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tla_pkg::in_t               in_data,
  // result output
  output logic                       out_valid,
  input  logic                       out_stall,
  output tla_pkg::out_t              out_data,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tla_pkg::ADDR_W-1:0] paddr,
  input  logic [tla_pkg::DATA_W-1:0] pwdata,
  output logic [tla_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import tla_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_GEN, S_RESP} state_t;

  cfg_t cfg;

  // sequencer state
  state_t             state_r;
  logic               cur_bank_r;     // bank holding the visible grid
  logic               out_valid_r;
  out_t               out_data_r;
  out_t               res_r;          // finished result waiting for the output
  logic [COL_W-1:0]   col_r;
  logic [SIZE_W-1:0]  rd_k_r;         // read step within a generation
  logic               issue_done_r;
  logic               rdv_r;          // row data arriving this cycle
  logic [SIZE_W-1:0]  rdk_r;          // read step of arriving row
  logic [COUNT_W-1:0] gen_r;
  logic               chg_r;          // some cell changed in this generation
  logic [MAX_WIDTH-1:0] north_r;
  logic [MAX_WIDTH-1:0] mid_r;

  // bank ports
  logic [ROW_W-1:0]     act_addr, dst_addr;
  logic                 act_re;
  logic [MAX_WIDTH-1:0] act_mask, act_wdata, dst_mask;
  logic [ROW_W-1:0]     b0_addr, b1_addr;
  logic                 b0_re, b1_re;
  logic [MAX_WIDTH-1:0] b0_mask, b1_mask, b0_wdata, b1_wdata;
  logic [MAX_WIDTH-1:0] b0_rdata, b1_rdata, rdata_cur;

  // row update
  logic [MAX_WIDTH-1:0] next_row, use_mask;
  logic                 row_chg;

  logic              in_fire, out_free, out_load, in_bounds, issue, gen_last, wr_row_en;
  logic              chg_all;
  logic [SIZE_W-1:0] last_k;
  logic [ROW_W-1:0]  rd_row;
  logic [COUNT_W-1:0] gen_nxt;

  tla_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // handshake
  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_RESP) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_bounds = (SIZE_W'(in_data.row) < cfg.height)
                  && (SIZE_W'(in_data.column) < cfg.width);

  // a generation reads rows h-1, 0, 1 .. h-1, 0 so every row sees both
  // wrapped neighbors; steps 0 .. h+1
  assign last_k = cfg.height + SIZE_W'(1);
  assign issue  = (state_r == S_GEN) && !issue_done_r;

  always_comb begin
    priority if (rd_k_r == '0)  rd_row = ROW_W'(cfg.height - SIZE_W'(1));
    else if (rd_k_r == last_k)  rd_row = '0;
    else                        rd_row = ROW_W'(rd_k_r - SIZE_W'(1));
  end

  // row k-2 is complete once the row of step k arrives
  assign wr_row_en = rdv_r && (rdk_r >= SIZE_W'(2));
  assign gen_last  = rdv_r && (rdk_r == last_k);
  assign chg_all   = chg_r | row_chg;
  assign gen_nxt   = gen_r + COUNT_W'(1);

  // visible bank: host accesses and generation reads
  // the other bank only takes writes, so reads and writes never share an
  // entry inside a generation; the next one starts after the last write
  assign act_addr  = (state_r == S_GEN) ? rd_row : ROW_W'(in_data.row);
  assign act_re    = issue || (in_fire && (in_data.opcode == OP_READ) && in_bounds);
  assign act_mask  = (in_fire && (in_data.opcode == OP_WRITE) && in_bounds)
                   ? (MAX_WIDTH'(1) << in_data.column) : '0;
  assign act_wdata = {MAX_WIDTH{in_data.new_cell}};

  // other bank: next generation rows, only columns in use
  assign dst_addr = ROW_W'(rdk_r - SIZE_W'(2));
  assign dst_mask = wr_row_en ? use_mask : '0;

  assign b0_addr  = cur_bank_r ? dst_addr : act_addr;
  assign b0_re    = cur_bank_r ? 1'b0     : act_re;
  assign b0_mask  = cur_bank_r ? dst_mask : act_mask;
  assign b0_wdata = cur_bank_r ? next_row : act_wdata;
  assign b1_addr  = cur_bank_r ? act_addr : dst_addr;
  assign b1_re    = cur_bank_r ? act_re   : 1'b0;
  assign b1_mask  = cur_bank_r ? act_mask : dst_mask;
  assign b1_wdata = cur_bank_r ? act_wdata : next_row;

  assign rdata_cur = cur_bank_r ? b1_rdata : b0_rdata;

  tla_bank #(
    .DEPTH (MAX_HEIGHT),
    .WIDTH (MAX_WIDTH)
  ) u_bank0 (
    .clk     (clk),
    .addr    (b0_addr),
    .re      (b0_re),
    .we_mask (b0_mask),
    .wdata   (b0_wdata),
    .rdata   (b0_rdata)
  );

  tla_bank #(
    .DEPTH (MAX_HEIGHT),
    .WIDTH (MAX_WIDTH)
  ) u_bank1 (
    .clk     (clk),
    .addr    (b1_addr),
    .re      (b1_re),
    .we_mask (b1_mask),
    .wdata   (b1_wdata),
    .rdata   (b1_rdata)
  );

  // arriving row is the south neighbor of the row being finished
  tla_row_logic u_row (
    .north    (north_r),
    .mid      (mid_r),
    .south    (rdata_cur),
    .width    (cfg.width),
    .next_row (next_row),
    .use_mask (use_mask),
    .changed  (row_chg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_bank_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      rd_k_r       <= '0;
      issue_done_r <= 1'b0;
      rdv_r        <= 1'b0;
      rdk_r        <= '0;
      gen_r        <= '0;
      chg_r        <= 1'b0;
    end else begin
      // output register: load a finished result or retire the taken one
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_r.read_cell <= 1'b0;
            col_r           <= COL_W'(in_data.column);
            priority if (in_data.opcode == OP_WRITE) begin
              res_r.status <= !in_bounds;
              state_r      <= S_RESP;
            end else if (in_data.opcode == OP_READ) begin
              res_r.status <= !in_bounds;
              state_r      <= in_bounds ? S_READ : S_RESP;
            end else if (in_data.opcode == OP_RUN) begin
              res_r.status <= 1'b0;
              rd_k_r       <= '0;
              issue_done_r <= 1'b0;
              rdv_r        <= 1'b0;
              gen_r        <= '0;
              chg_r        <= 1'b0;
              state_r      <= (cfg.gen_count == '0) ? S_RESP : S_GEN;
            end else begin
              // unused opcode
              res_r.status <= 1'b1;
              state_r      <= S_RESP;
            end
          end
        end

        S_READ: begin
          res_r.read_cell <= rdata_cur[col_r];
          state_r         <= S_RESP;
        end

        S_GEN: begin
          if (issue) begin
            rd_k_r <= rd_k_r + SIZE_W'(1);
            if (rd_k_r == last_k) begin
              issue_done_r <= 1'b1;
            end
          end
          rdv_r <= issue;
          rdk_r <= rd_k_r;
          if (rdv_r) begin
            north_r <= mid_r;
            mid_r   <= rdata_cur;
          end
          if (wr_row_en && !gen_last) begin
            chg_r <= chg_all;
          end
          if (gen_last) begin
            if (chg_all && (gen_nxt != cfg.gen_count)) begin
              // next generation from the bank just written
              cur_bank_r   <= !cur_bank_r;
              gen_r        <= gen_nxt;
              rd_k_r       <= '0;
              issue_done_r <= 1'b0;
              chg_r        <= 1'b0;
            end else begin
              // done: new bank; stable grid: banks agree, keep full-run parity
              cur_bank_r <= chg_all ? !cur_bank_r
                                    : (cur_bank_r ^ cfg.gen_count[0] ^ gen_r[0]);
              state_r    <= S_RESP;
            end
          end
        end

        S_RESP: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the toroidal b3/s23 life automaton: a cycle-free
// shadow of both grid banks predicts every result, while both sides of the
// item channel idle at random and the apb port moves through grid shapes
// ----------------------------------------------------------------------------
module testbench;
  import tla_pkg::*;

  // opcode that the block must refuse
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CELLS       = MAX_WIDTH * MAX_HEIGHT;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [ADDR_W-1:0]    paddr     = '0;
  logic [DATA_W-1:0]    pwdata    = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  toroidal_life_automaton u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // shadow of the block: both banks, the visible bank and the registers
  logic               cell_bank [2][CELLS];
  logic               shown_bank;
  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;
  logic [COUNT_W-1:0] gen_reg;

  // answers still owed by the block, oldest first
  out_t expected_answers [$];

  int failures;
  int cycle_count;
  // idling odds in percent per cycle or per item, zero turns idling off
  int gap_pct;
  int stall_pct;
  int stall_left;
  // long receiver hold-off, armed by a test and counted down below
  int long_hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // sizes below three or above the storage limit are pulled into range
  function automatic int clamp_side(logic [SIZE_W-1:0] v, int limit);
    if (v < MIN_SIZE) return int'(MIN_SIZE);
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function automatic int used_width();
    return clamp_side(width_reg, MAX_WIDTH);
  endfunction

  function automatic int used_height();
    return clamp_side(height_reg, MAX_HEIGHT);
  endfunction

  // one generation from the visible bank into the other; tells if anything moved
  function automatic bit advance_generation(int w, int h);
    int   src;
    int   dst;
    int   r;
    int   c;
    int   rn;
    int   rs;
    int   cw;
    int   ce;
    int   n;
    logic self_alive;
    logic next_alive;
    bit   changed;
    src = int'(shown_bank);
    dst = 1 - src;
    changed = 1'b0;
    for (r = 0; r < h; r++) begin
      // rows and columns wrap around the torus
      rn = (r == 0) ? h - 1 : r - 1;
      rs = (r + 1 == h) ? 0 : r + 1;
      for (c = 0; c < w; c++) begin
        cw = (c == 0) ? w - 1 : c - 1;
        ce = (c + 1 == w) ? 0 : c + 1;
        n = int'(cell_bank[src][rn*MAX_WIDTH+cw]) + int'(cell_bank[src][rn*MAX_WIDTH+c])
          + int'(cell_bank[src][rn*MAX_WIDTH+ce]) + int'(cell_bank[src][r*MAX_WIDTH+cw])
          + int'(cell_bank[src][r*MAX_WIDTH+ce]) + int'(cell_bank[src][rs*MAX_WIDTH+cw])
          + int'(cell_bank[src][rs*MAX_WIDTH+c]) + int'(cell_bank[src][rs*MAX_WIDTH+ce]);
        self_alive = cell_bank[src][r*MAX_WIDTH+c];
        next_alive = (n == int'(BIRTH_COUNT)) || (n == int'(SURVIVE_COUNT) && self_alive);
        if (next_alive != self_alive) changed = 1'b1;
        cell_bank[dst][r*MAX_WIDTH+c] = next_alive;
      end
    end
    return changed;
  endfunction

  function automatic void run_generations(int w, int h);
    int g;
    for (g = 0; g < int'(gen_reg); g++) begin
      if (!advance_generation(w, h)) begin
        shown_bank = ~shown_bank;
        // settled grid: the bank that the full count would end on is shown
        if (((int'(gen_reg) - g - 1) & 1) != 0) shown_bank = ~shown_bank;
        break;
      end
      shown_bank = ~shown_bank;
    end
  endfunction

  function automatic out_t predict_answer(in_t cmd);
    out_t ans;
    int   w;
    int   h;
    int   idx;
    ans = '0;
    w = used_width();
    h = used_height();
    case (cmd.opcode)
      OP_WRITE, OP_READ: begin
        if (int'(cmd.row) < h && int'(cmd.column) < w) begin
          idx = int'(cmd.row) * MAX_WIDTH + int'(cmd.column);
          if (cmd.opcode == OP_WRITE) cell_bank[shown_bank][idx] = cmd.new_cell;
          else ans.read_cell = cell_bank[shown_bank][idx];
        end else begin
          // coordinate outside the grid in use
          ans.status = 1'b1;
        end
      end
      OP_RUN: run_generations(w, h);
      default: ans.status = 1'b1;
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall bursts, long hold-off and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (long_hold_left > 0) begin
      long_hold_left = long_hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      // stall burst of random length, this cycle included
      stall_left = $urandom_range(13, 1) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // every result transfer is matched with the oldest answer owed
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $error("result transfer with no command outstanding: read_cell %0d status %0d",
               out_data.read_cell, out_data.status);
        failures++;
      end else begin
        want = expected_answers.pop_front();
        if (out_data.read_cell !== want.read_cell) begin
          $error("read_cell: expected %0d, actual %0d", want.read_cell, out_data.read_cell);
          failures++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          failures++;
        end
      end
    end
  end

  // watchdog for a hung block
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // item side
  // ---------------------------------------------------------------------------

  function automatic in_t make_cmd(logic [1:0] op, int r, int c, logic v);
    in_t cmd;
    cmd.opcode   = op;
    cmd.row      = 6'(r);
    cmd.column   = 6'(c);
    cmd.new_cell = v;
    return cmd;
  endfunction

  // offers one command and returns at the edge of its transfer; valid stays
  // high so that a following command can go out back to back
  task automatic send_command(in_t cmd);
    int gap;
    gap = 0;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) gap = $urandom_range(13, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_answers.push_back(predict_answer(cmd));
  endtask

  // sender drops valid and waits for every answer owed
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  // apb write while the block is idle: setup cycle, then access cycle
  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    wait_drain();
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // register taken at this edge
    case (idx)
      REG_GRID_WIDTH:  width_reg  = value[SIZE_W-1:0];
      REG_GRID_HEIGHT: height_reg = value[SIZE_W-1:0];
      REG_GEN_COUNT:   gen_reg    = value[COUNT_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(logic [REG_IDX_W-1:0] idx, int bits, int want);
    logic [DATA_W-1:0] got;
    logic [DATA_W-1:0] mask;
    wait_drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got  = prdata;
    mask = (DATA_W'(1) << bits) - 1;
    if ((got & mask) !== (DATA_W'(want) & mask)) begin
      $error("register %0d: expected %0d, actual %0d", idx, want, got & mask);
      failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_geometry(int w_val, int h_val, int gen_val);
    cfg_write(REG_GRID_WIDTH, DATA_W'(w_val));
    cfg_write(REG_GRID_HEIGHT, DATA_W'(h_val));
    cfg_write(REG_GEN_COUNT, DATA_W'(gen_val));
  endtask

  // every cell in use gets written before anything reads or runs
  task automatic fill_grid(int alive_pct);
    int r;
    int c;
    int w;
    int h;
    w = used_width();
    h = used_height();
    for (r = 0; r < h; r++)
      for (c = 0; c < w; c++)
        send_command(make_cmd(OP_WRITE, r, c, $urandom_range(99) < alive_pct));
  endtask

  // mostly good reads and writes inside the grid, some runs, some noise
  task automatic issue_random_commands(int count, int run_pct);
    int   k;
    int   roll;
    int   w;
    int   h;
    in_t  cmd;
    for (k = 0; k < count; k++) begin
      w = used_width();
      h = used_height();
      cmd = make_cmd(OP_WRITE, $urandom_range(63), $urandom_range(63), $urandom_range(1));
      roll = $urandom_range(99);
      if (roll < run_pct) begin
        cmd.opcode = OP_RUN;
      end else if (roll < run_pct + 40) begin
        cmd.opcode = OP_READ;
        cmd.row    = 6'($urandom_range(h - 1));
        cmd.column = 6'($urandom_range(w - 1));
      end else if (roll < run_pct + 75) begin
        cmd.row    = 6'($urandom_range(h - 1));
        cmd.column = 6'($urandom_range(w - 1));
      end else if (roll < run_pct + 92) begin
        // coordinate pushed past the edge where the grid leaves room
        cmd.opcode = $urandom_range(1) ? OP_READ : OP_WRITE;
        if (h < MAX_HEIGHT && $urandom_range(1)) cmd.row = 6'($urandom_range(63, h));
        else if (w < MAX_WIDTH) cmd.column = 6'($urandom_range(63, w));
      end else begin
        cmd.opcode = OP_UNUSED;
      end
      send_command(cmd);
    end
  endtask

  function automatic int pick_side_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return $urandom_range(10, 3);
    if (roll < 75) return $urandom_range(64, 11);
    if (roll < 87) return $urandom_range(127, 65);
    return $urandom_range(2, 0);
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 50;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_register_defaults();
    check_register(REG_GRID_WIDTH, SIZE_W, 64);
    check_register(REG_GRID_HEIGHT, SIZE_W, 64);
    check_register(REG_GEN_COUNT, COUNT_W, 1);
  endtask

  // 3x3 torus from sizes below the minimum, edge coordinates, refused opcode,
  // zero and full generation counts
  task automatic test_directed_cases();
    int c;
    set_geometry(0, 2, 0);
    check_register(REG_GRID_WIDTH, SIZE_W, 0);
    for (c = 0; c < 3; c++) send_command(make_cmd(OP_WRITE, 0, c, 1'b1));
    for (c = 0; c < 3; c++) send_command(make_cmd(OP_WRITE, 1, c, 1'b0));
    for (c = 0; c < 3; c++) send_command(make_cmd(OP_WRITE, 2, c, 1'b0));
    send_command(make_cmd(OP_READ, 0, 0, 1'b0));
    send_command(make_cmd(OP_READ, 2, 2, 1'b1));
    // outside the grid: nothing changes
    send_command(make_cmd(OP_WRITE, 63, 63, 1'b1));
    send_command(make_cmd(OP_WRITE, 2, 3, 1'b1));
    send_command(make_cmd(OP_READ, 3, 0, 1'b0));
    send_command(make_cmd(OP_READ, 0, 63, 1'b0));
    send_command(make_cmd(OP_UNUSED, 63, 63, 1'b1));
    send_command(make_cmd(OP_UNUSED, 0, 0, 1'b0));
    // zero generations leaves the grid alone
    send_command(make_cmd(OP_RUN, 0, 0, 1'b0));
    send_command(make_cmd(OP_READ, 0, 1, 1'b0));
    send_command(make_cmd(OP_READ, 1, 1, 1'b0));
    // three alive fill the grid, then all die and it settles
    cfg_write(REG_GEN_COUNT, DATA_W'(1));
    send_command(make_cmd(OP_RUN, 63, 63, 1'b1));
    send_command(make_cmd(OP_READ, 2, 0, 1'b0));
    cfg_write(REG_GEN_COUNT, DATA_W'(65535));
    send_command(make_cmd(OP_RUN, 0, 0, 1'b0));
    send_command(make_cmd(OP_READ, 1, 1, 1'b0));
    send_command(make_cmd(OP_READ, 0, 2, 1'b0));
    check_register(REG_GEN_COUNT, COUNT_W, 65535);
  endtask

  task automatic test_random_phases(int phases);
    int p;
    int wv;
    int hv;
    int gv;
    for (p = 0; p < phases; p++) begin
      wv = pick_side_value();
      hv = pick_side_value();
      // keep the fill short when one side is long
      if (clamp_side(SIZE_W'(wv), MAX_WIDTH) > 16)
        hv = $urandom_range(4, 3);
      else if (clamp_side(SIZE_W'(hv), MAX_HEIGHT) > 16)
        wv = $urandom_range(4, 3);
      if (clamp_side(SIZE_W'(wv), MAX_WIDTH) == 3 && clamp_side(SIZE_W'(hv), MAX_HEIGHT) == 3
          && $urandom_range(1))
        gv = $urandom_range(65535, 1000);  // a 3x3 torus always settles quickly
      else if ($urandom_range(3) == 0)
        gv = $urandom_range(20, 7);
      else
        gv = $urandom_range(5, 0);
      set_geometry(wv, hv, gv);
      gap_pct   = pick_idle_pct();
      stall_pct = pick_idle_pct();
      fill_grid($urandom_range(70, 20));
      issue_random_commands(50, 10);
    end
  endtask

  // receiver holds off while the sender keeps offering, then a full drain and random stalls
  task automatic test_backpressure();
    wait_drain();
    gap_pct = 0;
    stall_pct = 0;
    long_hold_left = 400;
    issue_random_commands(40, 5);
    wait_drain();
    repeat (3) @(posedge clk);
    stall_pct = 20;
    issue_random_commands(20, 10);
  endtask

  // widest grid, width above the limit pulled in, with no idling at all
  task automatic test_full_grid();
    gap_pct = 0;
    stall_pct = 0;
    set_geometry(127, 3, 2);
    wait_drain();
    stall_left = 0;
    fill_grid(35);
    issue_random_commands(100, 5);
  endtask

  initial begin
    int i;
    for (i = 0; i < CELLS; i++) begin
      cell_bank[0][i] = 1'b0;
      cell_bank[1][i] = 1'b0;
    end
    shown_bank     = 1'b0;
    width_reg      = SIZE_W'(64);
    height_reg     = SIZE_W'(64);
    gen_reg        = COUNT_W'(1);
    failures       = 0;
    cycle_count    = 0;
    gap_pct        = 0;
    stall_pct      = 0;
    stall_left     = 0;
    long_hold_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_defaults();
    test_directed_cases();
    test_random_phases(5);
    test_backpressure();
    test_full_grid();

    wait_drain();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
